[rtl/core/mrr_pkg.sv]
// ---------------------------------------------------------------------------
// mrr_pkg: shared types and constants for the Modbus RTU register read master
// Frame constants, result codes, the controller states, the command and
// status groups between controller and datapath, and the CRC-16 byte step.
// ---------------------------------------------------------------------------
package mrr_pkg;

  // Reply sizing
  localparam int MAX_REGS    = 4;
  localparam int REPLY_DEPTH = 5 + 2 * MAX_REGS;
  localparam int RX_IDX_W    = $clog2(REPLY_DEPTH);
  localparam int CNT_W       = $clog2(REPLY_DEPTH + 1);

  localparam logic [RX_IDX_W-1:0] RX_LAST  = RX_IDX_W'(REPLY_DEPTH - 1);
  localparam logic [CNT_W-1:0]    RX_DEPTH = CNT_W'(REPLY_DEPTH);
  localparam logic [2:0]          MAX_CNT  = 3'(MAX_REGS);

  // Protocol constants
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Register reset values
  localparam logic [7:0]  RST_POLL_ADDR  = 8'd1;
  localparam logic [15:0] RST_START_REG  = 16'h0809;
  localparam logic [2:0]  RST_REG_COUNT  = 3'd4;
  localparam logic [15:0] RST_TIMEOUT    = 16'd200;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLL_ADDR  = 2'd0;
  localparam logic [1:0] CFG_START_REG  = 2'd1;
  localparam logic [1:0] CFG_REG_COUNT  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

  // Input request kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result kinds
  localparam logic [1:0] OUT_TX     = 2'd0;
  localparam logic [1:0] OUT_REG    = 2'd1;
  localparam logic [1:0] OUT_STATUS = 2'd2;

  // Transaction status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_TIMEOUT = 3'd1;
  localparam logic [2:0] STAT_CRC     = 3'd2;
  localparam logic [2:0] STAT_ADDR    = 3'd3;
  localparam logic [2:0] STAT_COUNT   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_TX,
    ST_SWEEP,
    ST_EVAL,
    ST_REG_HI,
    ST_REG_LO,
    ST_STAT
  } mrr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic wait_clr;     // new transaction: clear counters, init CRC
    logic byte_store;   // buffer a reply byte
    logic sweep_init;   // reply complete: restart CRC and pointer
    logic tick_inc;     // count one tick
    logic timeout_set;  // latch timeout status
    logic tx_load;      // load next request byte into the output
    logic sweep_step;   // fold one stored byte into the CRC check
    logic eval_load;    // latch reply status
    logic reg_hold;     // hold high byte of a register value
    logic reg_load;     // load a register value into the output
    logic stat_load;    // load the status into the output
  } mrr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic tx_done;
    logic reply_done;
    logic timeout_hit;
    logic sweep_done;
    logic status_ok;
    logic reg_done;
  } mrr_sts_t;

  // CRC-16, reflected polynomial, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/mrr_ctrl.sv]
// ---------------------------------------------------------------------------
// mrr_ctrl: transaction controller
// Sequences request emission, reply collection, the reply check sweep and
// the emission of register values and status.
// ---------------------------------------------------------------------------
module mrr_ctrl
  import mrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] kind,
  output logic       in_ready,
  input  mrr_sts_t   sts,
  output mrr_cmd_t   cmd
);

  mrr_state_t state;
  mrr_state_t state_next;
  logic       accept;

  // Take requests only while idle or waiting for the reply
  assign in_ready = (state == ST_IDLE) || (state == ST_WAIT);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_START) state_next = ST_TX;
      end
      ST_WAIT: begin
        if (accept) begin
          case (kind)
            KIND_START: state_next = ST_TX;
            KIND_BYTE:  if (sts.reply_done) state_next = ST_SWEEP;
            KIND_TICK:  if (sts.timeout_hit) state_next = ST_STAT;
            default:    state_next = ST_WAIT;
          endcase
        end
      end
      ST_TX: begin
        if (sts.out_free && sts.tx_done) state_next = ST_WAIT;
      end
      ST_SWEEP: begin
        if (sts.sweep_done) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = sts.status_ok ? ST_REG_HI : ST_STAT;
      end
      ST_REG_HI: begin
        state_next = ST_REG_LO;
      end
      ST_REG_LO: begin
        if (sts.out_free) state_next = sts.reg_done ? ST_STAT : ST_REG_HI;
      end
      ST_STAT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.wait_clr = accept && kind == KIND_START;
      end
      ST_WAIT: begin
        if (accept) begin
          case (kind)
            KIND_START: cmd.wait_clr = 1'b1;
            KIND_BYTE: begin
              cmd.byte_store = 1'b1;
              cmd.sweep_init = sts.reply_done;
            end
            KIND_TICK: begin
              cmd.tick_inc    = 1'b1;
              cmd.timeout_set = sts.timeout_hit;
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_TX:     cmd.tx_load    = sts.out_free;
      ST_SWEEP:  cmd.sweep_step = 1'b1;
      ST_EVAL:   cmd.eval_load  = 1'b1;
      ST_REG_HI: cmd.reg_hold   = 1'b1;
      ST_REG_LO: cmd.reg_load   = sts.out_free;
      ST_STAT:   cmd.stat_load  = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

[rtl/core/mrr_dpath.sv]
// ---------------------------------------------------------------------------
// mrr_dpath: transaction datapath
// Configuration registers, reply byte buffer, counters, the shared CRC-16
// unit, reply checks and the output result register.
// ---------------------------------------------------------------------------
module mrr_dpath
  import mrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [7:0]  rx_byte,
  input  mrr_cmd_t    cmd,
  output mrr_sts_t    sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  tx_byte,
  output logic [1:0]  reg_index,
  output logic [15:0] reg_value,
  output logic [2:0]  status,
  output logic        last
);

  // Configuration
  logic [7:0]  poll_addr;
  logic [15:0] start_register;
  logic [2:0]  register_count;
  logic [15:0] timeout_ticks;

  // Transaction state
  logic [7:0]          reply_bytes [REPLY_DEPTH];
  logic [CNT_W-1:0]    received_count;
  logic [15:0]         elapsed_ticks;
  logic [15:0]         crc;
  logic [15:0]         got_crc;
  logic [RX_IDX_W-1:0] idx;
  logic [1:0]          reg_num;
  logic [7:0]          hold_byte;
  logic [2:0]          stat_reg;

  logic [2:0]          n;
  logic [CNT_W-1:0]    expected;
  logic [15:0]         elapsed_next;
  logic [7:0]          rd_byte;
  logic [7:0]          tx_cur;
  logic                sweep_crc;
  logic                crc_en;
  logic [7:0]          crc_in;
  logic [2:0]          eval_status;
  logic                out_load;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_addr      <= RST_POLL_ADDR;
      start_register <= RST_START_REG;
      register_count <= RST_REG_COUNT;
      timeout_ticks  <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL_ADDR:  poll_addr      <= cfg_data[7:0];
        CFG_START_REG:  start_register <= cfg_data;
        CFG_REG_COUNT:  register_count <= cfg_data[2:0];
        CFG_TIMEOUT:    timeout_ticks  <= cfg_data;
        default:        poll_addr      <= poll_addr;
      endcase
    end
  end

  // Clamp register count and derive the reply length
  always_comb begin
    if (register_count == 3'd0) begin
      n = 3'd1;
    end else if (register_count > MAX_CNT) begin
      n = MAX_CNT;
    end else begin
      n = register_count;
    end
  end

  assign expected = CNT_W'(5) + CNT_W'({n, 1'b0});

  // Indexed read port into the reply buffer; the reply check reads bytes 0 to 2 directly
  assign rd_byte = (idx <= RX_LAST) ? reply_bytes[idx] : 8'h00;

  // Request frame byte at the current position
  always_comb begin
    case (idx[2:0])
      3'd0:    tx_cur = poll_addr;
      3'd1:    tx_cur = FUNC_READ_HOLD;
      3'd2:    tx_cur = start_register[15:8];
      3'd3:    tx_cur = start_register[7:0];
      3'd4:    tx_cur = 8'h00;
      3'd5:    tx_cur = {5'd0, n};
      3'd6:    tx_cur = crc[7:0];
      3'd7:    tx_cur = crc[15:8];
      default: tx_cur = 8'h00;
    endcase
  end

  // Buffer reply bytes and count ticks
  assign elapsed_next = elapsed_ticks + 16'd1;

  always_ff @(posedge clk) begin
    if (cmd.byte_store && received_count < RX_DEPTH) begin
      reply_bytes[received_count[RX_IDX_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_count <= '0;
      elapsed_ticks  <= '0;
    end else if (cmd.wait_clr) begin
      received_count <= '0;
      elapsed_ticks  <= '0;
    end else begin
      if (cmd.byte_store && received_count < RX_DEPTH) received_count <= received_count + 1'b1;
      if (cmd.tick_inc) elapsed_ticks <= elapsed_next;
    end
  end

  // Shared CRC unit: request bytes while sending, stored bytes while checking
  assign sweep_crc = CNT_W'(idx) < (expected - CNT_W'(2));
  assign crc_en    = (cmd.tx_load && idx < RX_IDX_W'(6)) || (cmd.sweep_step && sweep_crc);
  assign crc_in    = cmd.tx_load ? tx_cur : rd_byte;

  always_ff @(posedge clk) begin
    if (cmd.wait_clr || cmd.sweep_init) begin
      crc <= CRC_INIT;
    end else if (crc_en) begin
      crc <= crc_byte(crc, crc_in);
    end
  end

  // Shift in the received CRC, low byte first
  always_ff @(posedge clk) begin
    if (cmd.sweep_step && !sweep_crc) begin
      got_crc <= {rd_byte, got_crc[15:8]};
    end
  end

  // Advance the buffer pointer
  always_ff @(posedge clk) begin
    if (cmd.wait_clr || cmd.sweep_init) begin
      idx <= '0;
    end else if (cmd.eval_load) begin
      idx <= RX_IDX_W'(3);
    end else if (cmd.tx_load || cmd.sweep_step || cmd.reg_hold || cmd.reg_load) begin
      idx <= idx + 1'b1;
    end
  end

  // Judge the reply: CRC, then address and function, then byte count
  always_comb begin
    if (got_crc != crc) begin
      eval_status = STAT_CRC;
    end else if (reply_bytes[0] != poll_addr || reply_bytes[1] != FUNC_READ_HOLD) begin
      eval_status = STAT_ADDR;
    end else if (reply_bytes[2] != {4'd0, n, 1'b0}) begin
      eval_status = STAT_COUNT;
    end else begin
      eval_status = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.timeout_set) begin
      stat_reg <= STAT_TIMEOUT;
    end else if (cmd.eval_load) begin
      stat_reg <= eval_status;
    end
  end

  // Register value assembly
  always_ff @(posedge clk) begin
    if (cmd.reg_hold) hold_byte <= rd_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_load) begin
      reg_num <= 2'd0;
    end else if (cmd.reg_load) begin
      reg_num <= reg_num + 2'd1;
    end
  end

  // Output result register
  assign out_load = cmd.tx_load || cmd.reg_load || cmd.stat_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tx_load) begin
      out_kind  <= OUT_TX;
      tx_byte   <= tx_cur;
      reg_index <= 2'd0;
      reg_value <= 16'd0;
      status    <= STAT_OK;
      last      <= sts.tx_done;
    end else if (cmd.reg_load) begin
      out_kind  <= OUT_REG;
      tx_byte   <= 8'h00;
      reg_index <= reg_num;
      reg_value <= {hold_byte, rd_byte};
      status    <= STAT_OK;
      last      <= 1'b0;
    end else if (cmd.stat_load) begin
      out_kind  <= OUT_STATUS;
      tx_byte   <= 8'h00;
      reg_index <= 2'd0;
      reg_value <= 16'd0;
      status    <= stat_reg;
      last      <= 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    sts.out_free    = !out_valid || out_ready;
    sts.tx_done     = idx == RX_IDX_W'(7);
    sts.reply_done  = (received_count + 1'b1) >= expected;
    sts.timeout_hit = elapsed_next >= timeout_ticks;
    sts.sweep_done  = CNT_W'(idx) == (expected - CNT_W'(1));
    sts.status_ok   = eval_status == STAT_OK;
    sts.reg_done    = {1'b0, reg_num} == (n - 3'd1);
  end

endmodule

[rtl/core/modbus_rtu_register_read_master.sv]
// ---------------------------------------------------------------------------
// modbus_rtu_register_read_master: Modbus RTU read-holding-registers master
// Sends one function 0x03 request per start request, collects the reply, checks
// CRC, address, function and byte count, then returns the register values and a
// status; a failed check returns only a status, a spent tick budget a timeout status.
// ---------------------------------------------------------------------------
//
//   channel  signals                               direction
//   -------  ------------------------------------  ---------
//   in       in_valid/in_ready, kind, rx_byte       in
//   out      out_valid/out_ready, out_kind,         out
//            tx_byte, reg_index, reg_value,
//            status, last
//   cfg      cfg_valid/cfg_ready, cfg_index,        in
//            cfg_data
//
// A start request emits its 8 request bytes at one per cycle while out_ready is high.
// The byte that completes a 5+2N byte reply starts a check: a sweep over the buffer,
// an evaluation, then each register value in turn and finally the status.
// Bytes and ticks are otherwise taken at once; no request or register write is taken
// while a sequence runs. Reset restores register defaults, clears counters and idles.
// Results wait in one output register; a stalled output holds the sequence.
// ---------------------------------------------------------------------------
module modbus_rtu_register_read_master
  import mrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  tx_byte,
  output logic [1:0]  reg_index,
  output logic [15:0] reg_value,
  output logic [2:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mrr_cmd_t cmd;
  mrr_sts_t sts;

  // Take register writes only while idle or waiting for the reply
  assign cfg_ready = in_ready;

  mrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (rx_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .tx_byte   (tx_byte),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .status    (status),
    .last      (last)
  );

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    (cmd.tx_load || cmd.reg_load || cmd.stat_load) |-> sts.out_free)
    else $error("result loaded while output register busy");

  // At most one result source per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.tx_load, cmd.reg_load, cmd.stat_load}))
    else $error("conflicting result loads");

  // No request taken while the reply is being checked or emitted
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.sweep_step || cmd.eval_load || cmd.reg_hold || cmd.reg_load))
    else $error("request taken during reply sequence");

  // A register value is never the final result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == OUT_REG) |-> !last)
    else $error("register value marked last");

endmodule
